// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising edge, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at each rising edge, reset included.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

   // Table geometry
   localparam int ATOM_SLOTS = 4096;
   localparam int COORD_BITS = 32;
   localparam int COUNT_BITS = 10;

   localparam int ADDR_W  = $clog2(ATOM_SLOTS);
   localparam int COORD_W = (COORD_BITS >= 32) ? 32 : COORD_BITS;

   // Fixed field widths
   localparam int IDX_W     = 12;
   localparam int POS_W     = 32;
   localparam int RAD_W     = 31;
   localparam int MASK_W    = 32;
   localparam int CIN_W     = 10;
   localparam int OUT_CNT_W = 10;
   localparam int CFG_W     = 32;
   localparam int PADDR_W   = 3;

   // Contact test widths
   localparam int SQ_W  = 2 * COORD_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int RS_W  = RAD_W + 1;
   localparam int RSQ_W = 2 * RS_W;
   localparam int CMP_W = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;
   localparam int SAT_W = 33;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TALLY = 2'd1,
      OP_ADD   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic {
      REG_COMPUTE = 1'b0,
      REG_PARTNER = 1'b1
   } cfg_reg_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_WR,
      S_READ_OUT,
      S_T_B,
      S_T_DIFF,
      S_T_MUL,
      S_T_SUM,
      S_T_CMP,
      S_T_WB
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic        [RAD_W-1:0]   radius;
      logic        [MASK_W-1:0]  mask;
   } geom_type;

   localparam int GEOM_W = $bits(geom_type);

   // Slot index to memory address
   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [31:0] w;
      w = 32'(idx);
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic slot_ok(input logic [IDX_W-1:0] idx);
      return 32'(idx) < 32'(ATOM_SLOTS);
   endfunction

   // Count plus increment, clamped at the maximum
   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] base,
                                                     input logic [SAT_W-1:0]      inc);
      logic [SAT_W-1:0] sum;
      sum = SAT_W'(base) + inc;
      if (sum > SAT_W'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return sum[COUNT_BITS-1:0];
   endfunction

   // Low bits of a count as reported on the result word
   function automatic logic [OUT_CNT_W-1:0] out_count(input logic [COUNT_BITS-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[OUT_CNT_W-1:0];
   endfunction

   // Magnitude of a coordinate difference
   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port; read data holds without rd_en
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sphere_contact_counter_core.sv =====
// Load atom: writes the sphere and clears its count on accept; a new word is taken on the next cycle.
// Add count: count read, then saturating write back.
// Read count: count read, then rsp_valid is registered from S_READ_OUT once the result register is free.
// Tally pair: two reads of the sphere table through its one read port, followed by
//   difference, multiply, sum, compare and two count write backs.
// Reset: synchronous; then a clearing pass writes zero to each of the ATOM_SLOTS counts.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sphere_contact_counter_core (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [scc_pkg::IDX_W-1:0]          req_index_a,
   input  wire logic [scc_pkg::IDX_W-1:0]          req_index_b,
   input  wire logic signed [scc_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic signed [scc_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic signed [scc_pkg::POS_W-1:0]   req_pos_z,
   input  wire logic [scc_pkg::RAD_W-1:0]          req_sphere_radius,
   input  wire logic [scc_pkg::MASK_W-1:0]         req_group_mask,
   input  wire logic [scc_pkg::CIN_W-1:0]          req_count_in,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [scc_pkg::IDX_W-1:0]               rsp_atom_index,
   output logic [scc_pkg::OUT_CNT_W-1:0]           rsp_contact_count,

   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [scc_pkg::PADDR_W-1:0]        paddr,
   input  wire logic [scc_pkg::CFG_W-1:0]          pwdata,
   output logic [scc_pkg::CFG_W-1:0]               prdata,
   output logic                                    pready
);

   import scc_pkg::*;

   // Control state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]    compute_ff, partner_ff;

   // Captured word and tally datapath
   logic [IDX_W-1:0]      idx_a_ff, idx_b_ff;
   logic                  a_ok_ff;
   logic [CIN_W-1:0]      cin_ff;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [OUT_CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   geom_type              ga_ff;
   logic [COUNT_BITS-1:0] ca_ff, cb_ff;
   logic [COORD_W-1:0]    mag_x_ff, mag_y_ff, mag_z_ff;
   logic [RS_W-1:0]       rs_ff;
   logic                  upd_a_ff, upd_b_ff;
   logic [SQ_W-1:0]       sq_x_ff, sq_y_ff, sq_z_ff;
   logic [RSQ_W-1:0]      rsq_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic                  hit_ff;

   // Memory ports
   logic                  geo_we, geo_rd_en;
   logic [ADDR_W-1:0]     geo_raddr;
   geom_type              geo_wdata, geo_rdata;
   logic                  cnt_we, cnt_rd_en;
   logic [ADDR_W-1:0]     cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

   // Decoded request
   op_type                req_op;
   logic                  accept;
   logic                  a_ok, b_ok;
   logic                  hit;
   logic                  cfg_wr;
   cfg_reg_type           cfg_sel;

   assign req_op  = op_type'(req_opcode);
   assign a_ok    = slot_ok(req_index_a);
   assign b_ok    = slot_ok(req_index_b);
   assign req_ready = (state_ff == S_IDLE);
   assign accept  = req_valid && req_ready;
   assign hit     = CMP_W'(sum_ff) <= CMP_W'(rsq_ff);

   assign geo_wdata.x      = req_pos_x[COORD_W-1:0];
   assign geo_wdata.y      = req_pos_y[COORD_W-1:0];
   assign geo_wdata.z      = req_pos_z[COORD_W-1:0];
   assign geo_wdata.radius = req_sphere_radius;
   assign geo_wdata.mask   = req_group_mask;

   scc_ram #(
      .WIDTH (GEOM_W),
      .DEPTH (ATOM_SLOTS)
   ) u_geom_ram (
      .clock   (clock),
      .wr_en   (geo_we),
      .wr_addr (to_addr(req_index_a)),
      .wr_data (geo_wdata),
      .rd_en   (geo_rd_en),
      .rd_addr (geo_raddr),
      .rd_data (geo_rdata)
   );

   scc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (ATOM_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // Sequencer: next state, memory control, result register
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      geo_we       = 1'b0;
      geo_rd_en    = 1'b0;
      geo_raddr    = to_addr(req_index_a);
      cnt_we       = 1'b0;
      cnt_waddr    = to_addr(req_index_a);
      cnt_wdata    = '0;
      cnt_rd_en    = 1'b0;
      cnt_raddr    = to_addr(req_index_a);

      unique case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(ATOM_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_LOAD: begin
                     geo_we = a_ok;
                     cnt_we = a_ok;
                  end
                  OP_TALLY: begin
                     if (a_ok && b_ok && (req_index_a != req_index_b)) begin
                        geo_rd_en = 1'b1;
                        cnt_rd_en = 1'b1;
                        state_in  = S_T_B;
                     end
                  end
                  OP_ADD: begin
                     if (a_ok) begin
                        cnt_rd_en = 1'b1;
                        state_in  = S_ADD_WR;
                     end
                  end
                  OP_READ: begin
                     cnt_rd_en = 1'b1;
                     state_in  = S_READ_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = to_addr(idx_a_ff);
            cnt_wdata = sat_add(cnt_rdata, SAT_W'(cin_ff));
            state_in  = S_IDLE;
         end
         S_READ_OUT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_a_ff;
               rsp_count_in = a_ok_ff ? out_count(cnt_rdata) : '0;
               state_in     = S_IDLE;
            end
         end
         S_T_B: begin
            geo_rd_en = 1'b1;
            cnt_rd_en = 1'b1;
            geo_raddr = to_addr(idx_b_ff);
            cnt_raddr = to_addr(idx_b_ff);
            state_in  = S_T_DIFF;
         end
         S_T_DIFF: begin
            state_in = S_T_MUL;
         end
         S_T_MUL: begin
            state_in = S_T_SUM;
         end
         S_T_SUM: begin
            state_in = S_T_CMP;
         end
         S_T_CMP: begin
            cnt_we    = upd_a_ff && hit;
            cnt_waddr = to_addr(idx_a_ff);
            cnt_wdata = sat_add(ca_ff, SAT_W'(1'b1));
            state_in  = S_T_WB;
         end
         S_T_WB: begin
            cnt_we    = upd_b_ff && hit_ff;
            cnt_waddr = to_addr(idx_b_ff);
            cnt_wdata = sat_add(cb_ff, SAT_W'(1'b1));
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured word and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_a_ff <= req_index_a;
         idx_b_ff <= req_index_b;
         a_ok_ff  <= a_ok;
         cin_ff   <= req_count_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Tally datapath: one operation step per stage
   always_ff @(posedge clock) begin
      if (state_ff == S_T_B) begin
         ga_ff <= geo_rdata;
         ca_ff <= cnt_rdata;
      end
      if (state_ff == S_T_DIFF) begin
         cb_ff    <= cnt_rdata;
         mag_x_ff <= abs_diff(ga_ff.x, geo_rdata.x);
         mag_y_ff <= abs_diff(ga_ff.y, geo_rdata.y);
         mag_z_ff <= abs_diff(ga_ff.z, geo_rdata.z);
         rs_ff    <= RS_W'(ga_ff.radius) + RS_W'(geo_rdata.radius);
         upd_a_ff <= (|(ga_ff.mask & compute_ff)) && (|(geo_rdata.mask & partner_ff));
         upd_b_ff <= (|(geo_rdata.mask & compute_ff)) && (|(ga_ff.mask & partner_ff));
      end
      if (state_ff == S_T_MUL) begin
         sq_x_ff <= SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
         sq_y_ff <= SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);
         sq_z_ff <= SQ_W'(mag_z_ff) * SQ_W'(mag_z_ff);
         rsq_ff  <= RSQ_W'(rs_ff) * RSQ_W'(rs_ff);
      end
      if (state_ff == S_T_SUM) begin
         sum_ff <= SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
      end
      if (state_ff == S_T_CMP) begin
         hit_ff <= hit;
      end
   end

   // Configuration registers
   assign cfg_sel = cfg_reg_type'(paddr[2]);
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign prdata  = (cfg_sel == REG_PARTNER) ? partner_ff : compute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         compute_ff <= CFG_W'(1);
         partner_ff <= CFG_W'(1);
      end else if (cfg_wr) begin
         if (cfg_sel == REG_PARTNER) begin
            partner_ff <= pwdata;
         end else begin
            compute_ff <= pwdata;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_atom_index    = rsp_index_ff;
   assign rsp_contact_count = rsp_count_ff;

   // Checks
   `ASSERT_CLK_NR(a_reset_clears, clock, reset |=> (state_ff == S_CLEAR) && (clr_ff == '0), "reset must start the clearing pass")
   `ASSERT_CLK(a_add_no_wrap, clock, reset, (state_ff == S_ADD_WR) |-> (cnt_wdata >= cnt_rdata), "add count wrapped")
   `ASSERT_CLK(a_rsp_from_read, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_READ_OUT), "result without read count")

endmodule
`default_nettype wire

// ===== tb/sphere_contact_counter_core_tb.sv =====
`timescale 1ns / 1ps
module sphere_contact_counter_core_tb;
   import scc_pkg::*;

   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam int SETTLE_CYCLES = 12;
   localparam int CHUNKS = 9;
   localparam int CHUNK_WORDS = 105;
   localparam int HOT_SLOTS = 24;

   // One request word as it crosses the input channel
   typedef struct {
      op_type      op;
      logic [11:0] index_a;
      logic [11:0] index_b;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [30:0] radius;
      logic [31:0] mask;
      logic [9:0]  count_in;
   } sphere_word_t;

   typedef struct {
      logic [11:0] atom_index;
      logic [9:0]  contact_count;
   } count_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [11:0] req_index_a = '0;
   logic [11:0] req_index_b = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [30:0] req_sphere_radius = '0;
   logic [31:0] req_group_mask = '0;
   logic [9:0]  req_count_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_atom_index;
   logic [9:0]  rsp_contact_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sphere_contact_counter_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_index_a       (req_index_a),
      .req_index_b       (req_index_b),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_sphere_radius (req_sphere_radius),
      .req_group_mask    (req_group_mask),
      .req_count_in      (req_count_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_atom_index    (rsp_atom_index),
      .rsp_contact_count (rsp_contact_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the sphere table and group registers
   logic signed [31:0] atom_x [4096];
   logic signed [31:0] atom_y [4096];
   logic signed [31:0] atom_z [4096];
   logic [30:0]        atom_radius [4096];
   logic [31:0]        atom_mask [4096];
   logic [9:0]         atom_count [4096];
   logic [31:0]        compute_bits = 32'd1;
   logic [31:0]        partner_bits = 32'd1;

   sphere_word_t  pending_words[$];
   count_result_t expected_counts[$];
   int            error_count = 0;
   int            sender_idle_pct = 0;
   int            receiver_idle_pct = 0;
   logic          word_taken = 1'b0;

   // Stimulus bookkeeping: which slots hold a sphere
   bit            slot_loaded [4096];
   int            loaded_slots[$];
   int            hot_slots [HOT_SLOTS];

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Magnitude of a coordinate difference, exact
   function automatic logic [32:0] coord_gap(input logic signed [31:0] p,
                                             input logic signed [31:0] q);
      logic signed [32:0] d;
      d = 33'(p) - 33'(q);
      return (d < 0) ? -d : d;
   endfunction

   function automatic bit spheres_touch(input int a, input int b);
      logic [32:0] dx;
      logic [32:0] dy;
      logic [32:0] dz;
      logic [67:0] dist_sq;
      logic [31:0] rsum;
      logic [67:0] rsum_sq;
      dx = coord_gap(atom_x[a], atom_x[b]);
      dy = coord_gap(atom_y[a], atom_y[b]);
      dz = coord_gap(atom_z[a], atom_z[b]);
      dist_sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
      rsum = 32'(atom_radius[a]) + 32'(atom_radius[b]);
      rsum_sq = 68'(rsum) * 68'(rsum);
      return dist_sq <= rsum_sq;
   endfunction

   // Saturating add into a slot count
   function automatic void bump_count(input int slot, input logic [9:0] add);
      logic [10:0] sum;
      sum = 11'(atom_count[slot]) + 11'(add);
      atom_count[slot] = sum[10] ? 10'h3FF : sum[9:0];
   endfunction

   // Apply one accepted word to the shadow table, queue any result
   function automatic void apply_to_table(input sphere_word_t w);
      int a;
      int b;
      bit upd_a;
      bit upd_b;
      count_result_t r;
      a = int'(w.index_a);
      b = int'(w.index_b);
      case (w.op)
         OP_LOAD: begin
            atom_x[a] = w.pos_x;
            atom_y[a] = w.pos_y;
            atom_z[a] = w.pos_z;
            atom_radius[a] = w.radius;
            atom_mask[a] = w.mask;
            atom_count[a] = '0;
         end
         OP_TALLY: begin
            if (a != b) begin
               upd_a = |(atom_mask[a] & compute_bits) && |(atom_mask[b] & partner_bits);
               upd_b = |(atom_mask[b] & compute_bits) && |(atom_mask[a] & partner_bits);
               if ((upd_a || upd_b) && spheres_touch(a, b)) begin
                  if (upd_a) bump_count(a, 10'd1);
                  if (upd_b) bump_count(b, 10'd1);
               end
            end
         end
         OP_ADD: begin
            bump_count(a, w.count_in);
         end
         default: begin
            r.atom_index = w.index_a;
            r.contact_count = atom_count[a];
            expected_counts.push_back(r);
         end
      endcase
   endfunction

   // Driver: next word at the falling edge once the last one was taken
   always @(negedge clock) begin
      sphere_word_t w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_opcode <= w.op;
            req_index_a <= w.index_a;
            req_index_b <= w.index_b;
            req_pos_x <= w.pos_x;
            req_pos_y <= w.pos_y;
            req_pos_z <= w.pos_z;
            req_sphere_radius <= w.radius;
            req_group_mask <= w.mask;
            req_count_in <= w.count_in;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Monitor: predict on accept, check each result word
   always @(posedge clock) begin
      sphere_word_t w;
      count_result_t e;
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            w.op = op_type'(req_opcode);
            w.index_a = req_index_a;
            w.index_b = req_index_b;
            w.pos_x = req_pos_x;
            w.pos_y = req_pos_y;
            w.pos_z = req_pos_z;
            w.radius = req_sphere_radius;
            w.mask = req_group_mask;
            w.count_in = req_count_in;
            apply_to_table(w);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               note_error($sformatf("unexpected result word: index %0d count %0d",
                                    rsp_atom_index, rsp_contact_count));
            end else begin
               e = expected_counts.pop_front();
               if (rsp_atom_index !== e.atom_index) begin
                  note_error($sformatf("atom_index: expected %0d, got %0d",
                                       e.atom_index, rsp_atom_index));
               end
               if (rsp_contact_count !== e.contact_count) begin
                  note_error($sformatf("contact_count (slot %0d): expected %0d, got %0d",
                                       e.atom_index, e.contact_count, rsp_contact_count));
               end
            end
         end
      end
   end

   function automatic sphere_word_t make_word(input op_type op, input int a, input int b,
                                              input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [31:0] r,
                                              input logic [31:0] m, input logic [31:0] c);
      sphere_word_t w;
      w.op = op;
      w.index_a = 12'(a);
      w.index_b = 12'(b);
      w.pos_x = x;
      w.pos_y = y;
      w.pos_z = z;
      w.radius = r[30:0];
      w.mask = m;
      w.count_in = c[9:0];
      return w;
   endfunction

   function automatic void queue_word(input sphere_word_t w);
      int a;
      a = int'(w.index_a);
      if (w.op == OP_LOAD && !slot_loaded[a]) begin
         slot_loaded[a] = 1'b1;
         loaded_slots.push_back(a);
      end
      pending_words.push_back(w);
   endfunction

   // Coordinate within a few units of the origin, so spheres overlap often
   function automatic logic [31:0] near_coord();
      int v;
      v = int'($urandom_range(32'h80000, 0)) - 32'h40000;
      return 32'(v);
   endfunction

   // A slot that already holds a sphere, mostly from the hot set
   function automatic int pick_loaded();
      int s;
      if ($urandom_range(99) < 80) begin
         s = hot_slots[$urandom_range(HOT_SLOTS - 1)];
         if (slot_loaded[s]) return s;
      end
      return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
   endfunction

   function automatic sphere_word_t random_word();
      sphere_word_t w;
      int pick;
      int a;
      bit hot;
      // Unused fields carry noise
      w.index_a = 12'($urandom);
      w.index_b = 12'($urandom);
      w.pos_x = $urandom;
      w.pos_y = $urandom;
      w.pos_z = $urandom;
      w.radius = 31'($urandom);
      w.mask = $urandom;
      w.count_in = 10'($urandom);
      hot = ($urandom_range(99) < 75);
      a = hot ? hot_slots[$urandom_range(HOT_SLOTS - 1)] : int'($urandom_range(4095));
      pick = $urandom_range(99);
      if (pick >= 25 && pick < 70 && loaded_slots.size() < 2) pick = 0;
      if (pick < 25) begin
         w.op = OP_LOAD;
         w.index_a = 12'(a);
         if ($urandom_range(99) < (hot ? 85 : 50)) begin
            w.pos_x = near_coord();
            w.pos_y = near_coord();
            w.pos_z = near_coord();
            w.radius = 31'($urandom_range(32'h30000, 0));
         end
         if ($urandom_range(99) < 60) w.mask = 32'($urandom_range(7, 0));
      end else if (pick < 70) begin
         w.op = OP_TALLY;
         a = pick_loaded();
         w.index_a = 12'(a);
         w.index_b = ($urandom_range(99) < 5) ? 12'(a) : 12'(pick_loaded());
      end else if (pick < 80) begin
         w.op = OP_ADD;
         w.index_a = 12'(a);
         if ($urandom_range(99) < 60) w.count_in = 10'($urandom_range(7, 0));
      end else begin
         w.op = OP_READ;
         w.index_a = 12'(a);
      end
      return w;
   endfunction

   task automatic csr_write(input cfg_reg_type which, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(4 * int'(which));
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (which == REG_COMPUTE) compute_bits = value;
      else partner_bits = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every word is in and every result is out
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_counts.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      logic [31:0] cfg_compute [CHUNKS];
      logic [31:0] cfg_partner [CHUNKS];
      cfg_compute = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_FFFF, 32'h1,
                      $urandom, 32'h3, $urandom, 32'hFFFF_FFFF};
      cfg_partner = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 32'h0, 32'h1,
                      $urandom, 32'h8000_0006, 32'hFFFF_FFFF, $urandom};
      // counts read as zero after reset
      foreach (atom_count[i]) atom_count[i] = '0;
      foreach (hot_slots[i]) hot_slots[i] = $urandom_range(4095);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset group settings
      sender_idle_pct = 28;
      receiver_idle_pct = 87;
      queue_word(make_word(OP_LOAD, 0, 0, 0, 0, 0, Q_ONE, 1, 0));
      // touching exactly at the radius sum
      queue_word(make_word(OP_LOAD, 1, 0, 2 * Q_ONE, 0, 0, Q_ONE, 1, 0));
      // one LSB past touching slot 0
      queue_word(make_word(OP_LOAD, 2, 0, 2 * Q_ONE + 1, 0, 0, Q_ONE, 1, 0));
      // outside both groups
      queue_word(make_word(OP_LOAD, 3, 0, 0, 0, 0, 5 * Q_ONE, 2, 0));
      queue_word(make_word(OP_LOAD, 4095, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
      queue_word(make_word(OP_LOAD, 2048, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           0, 32'hFFFF_FFFF, 0));
      queue_word(make_word(OP_LOAD, 7, 0, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
                           0, 1, 0));
      queue_word(make_word(OP_TALLY, 0, 1, 0, 0, 0, 0, 0, 0));
      // squared distance overflows 64 bits
      queue_word(make_word(OP_TALLY, 4095, 2048, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TALLY, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TALLY, 0, 2, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TALLY, 0, 3, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TALLY, 4095, 7, 0, 0, 0, 0, 0, 0));
      // saturate, then tally into a saturated count
      queue_word(make_word(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 32'h3FF));
      queue_word(make_word(OP_TALLY, 1, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_ADD, 1, 0, 0, 0, 0, 0, 0, 32'h3FF));
      queue_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0));
      // slot never loaded: count still cleared
      queue_word(make_word(OP_READ, 100, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_READ, 4095, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_READ, 7, 0, 0, 0, 0, 0, 0, 0));
      // reload clears the count
      queue_word(make_word(OP_LOAD, 0, 0, 0, 0, 0, Q_ONE, 1, 0));
      queue_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // Random chunks, group settings changed between them
      for (int c = 0; c < CHUNKS; c++) begin
         if (c < 3) begin
            sender_idle_pct = 28;
            receiver_idle_pct = 87;
         end else if (c < 6) begin
            sender_idle_pct = 87;
            receiver_idle_pct = 28;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         csr_write(REG_COMPUTE, cfg_compute[c]);
         csr_write(REG_PARTNER, cfg_partner[c]);
         for (int n = 0; n < CHUNK_WORDS; n++) queue_word(random_word());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
